FILE: rtl/krc_pkg.sv
// Shared types and constants for the keyed result cache.
// Holds the request and response words, opcode and outcome codes, and the
// command and status structs between the controller and the datapath.
`timescale 1ns / 1ps

package krc_pkg;

   // Default number of cache slots.
   localparam int ENTRIES_DEF = 16;

   // Field widths fixed by the interface.
   localparam int CAP_W = 5;
   localparam int OCC_W = 5;

   // Reset value of the capacity register.
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Saturation value of the per-entry hit counter.
   localparam logic [31:0] HITS_MAX = 32'hFFFF_FFFF;

   // Request opcodes.
   localparam logic [1:0] OP_LOOKUP     = 2'd0;
   localparam logic [1:0] OP_INSERT     = 2'd1;
   localparam logic [1:0] OP_INVALIDATE = 2'd2;

   // Response outcome codes.
   localparam logic [2:0] OUT_MISS        = 3'd0;
   localparam logic [2:0] OUT_HIT         = 3'd1;
   localparam logic [2:0] OUT_STALE       = 3'd2;
   localparam logic [2:0] OUT_REJECTED    = 3'd3;
   localparam logic [2:0] OUT_INSERTED    = 3'd4;
   localparam logic [2:0] OUT_UPDATED     = 3'd5;
   localparam logic [2:0] OUT_INVALIDATED = 3'd6;

   // One request word.
   typedef struct packed {
      logic [1:0]         opcode;
      logic [31:0]        rel_id;
      logic signed [63:0] fingerprint;
      logic signed [63:0] count_in;
      logic [31:0]        snapshot_horizon;
   } krc_req_type;

   // One response word.
   typedef struct packed {
      logic [2:0]         outcome;
      logic signed [63:0] count_out;
      logic [31:0]        hit_total;
      logic               evicted;
      logic [OCC_W-1:0]   occupancy;
   } krc_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic idx_clear;
      logic lk_match;
      logic lk_resolve;
      logic scan_step;
      logic ins_apply;
      logic sweep_step;
      logic reject;
   } krc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_lookup;
      logic is_insert_ok;
      logic is_invalidate;
      logic idx_last;
   } krc_status_type;

endpackage

FILE: rtl/keyed_result_cache_fifo_evict_core.sv
// Top level of the keyed result cache with oldest-first eviction.
// Joins krc_ctrl and krc_datapath; depends on krc_pkg.
//
//   Port group    Direction  Handshake
//   req_          in         start / busy, taken when start high, busy low
//   rsp_          out        rsp_valid strobe, one cycle, cannot be held off
//   csr_          in         csr_wr_en, written at once, no read-back
//
// After decode, a lookup goes through match, read and resolve, an insert
// through scan, drain and apply. Insert and invalidate walk the slots
// one per cycle: the age scan reads one age memory word per cycle and the
// sweep clears one slot per cycle. The result strobe follows in the cycle
// after busy falls, and a new word may be taken in that same cycle.
// Reset is synchronous; it empties the cache and sets the capacity to 16.
`timescale 1ns / 1ps

module keyed_result_cache_fifo_evict_core #(
   parameter int ENTRIES = krc_pkg::ENTRIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  krc_pkg::krc_req_type          req_data,
   output logic                          rsp_valid,
   output krc_pkg::krc_rsp_type          rsp_data,
   input  logic                          csr_wr_en,
   input  logic [krc_pkg::CAP_W-1:0]     csr_wr_data
);
   import krc_pkg::*;

   krc_cmd_type    cmd;
   krc_status_type status;

   // Sequencer.
   krc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // Storage and compute.
   krc_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule

FILE: rtl/krc_ctrl.sv
// Controller state machine of the keyed result cache.
// Sequences lookup, insert and invalidate words; depends on krc_pkg.
`timescale 1ns / 1ps

module krc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  krc_pkg::krc_status_type status,
   output krc_pkg::krc_cmd_type    cmd
);
   import krc_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_DECODE = 9'b000000010,
      ST_LMATCH = 9'b000000100,
      ST_LREAD  = 9'b000001000,
      ST_LRES   = 9'b000010000,
      ST_ISCAN  = 9'b000100000,
      ST_IDRAIN = 9'b001000000,
      ST_IAPPLY = 9'b010000000,
      ST_SWEEP  = 9'b100000000
   } krc_state_type;

   krc_state_type state_ff;
   krc_state_type state_in;

   // Next state and the command for the current cycle.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            priority if (status.is_lookup) begin
               state_in = ST_LMATCH;
            end else if (status.is_insert_ok) begin
               cmd.idx_clear = 1'b1;
               state_in      = ST_ISCAN;
            end else if (status.is_invalidate) begin
               cmd.idx_clear = 1'b1;
               state_in      = ST_SWEEP;
            end else begin
               cmd.reject = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_LMATCH: begin
            cmd.lk_match = 1'b1;
            state_in     = ST_LREAD;
         end
         ST_LREAD: begin
            // The entry memories deliver the matched slot's data.
            state_in = ST_LRES;
         end
         ST_LRES: begin
            cmd.lk_resolve = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_ISCAN: begin
            cmd.scan_step = 1'b1;
            if (status.idx_last) begin
               state_in = ST_IDRAIN;
            end
         end
         ST_IDRAIN: begin
            // The last age read is compared in this cycle.
            state_in = ST_IAPPLY;
         end
         ST_IAPPLY: begin
            cmd.ins_apply = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (status.idx_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

FILE: rtl/krc_datapath.sv
// Datapath of the keyed result cache: key lanes, entry memories, age scan,
// occupancy count, capacity register and response register. Uses krc_pkg.
`timescale 1ns / 1ps

module krc_datapath #(
   parameter int ENTRIES = krc_pkg::ENTRIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  krc_pkg::krc_cmd_type          cmd,
   output krc_pkg::krc_status_type       status,
   input  krc_pkg::krc_req_type          req_data,
   input  logic                          csr_wr_en,
   input  logic [krc_pkg::CAP_W-1:0]     csr_wr_data,
   output logic                          rsp_valid,
   output krc_pkg::krc_rsp_type          rsp_data
);
   import krc_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

   // Request word and configuration.
   krc_req_type      req_ff;
   logic [CAP_W-1:0] csr_ff;

   // Per-slot valid bits and key lanes.
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [31:0]        rel_ff [ENTRIES];
   logic [63:0]        key_ff [ENTRIES];

   // Entry memories with registered reads.
   logic [63:0] cnt_mem  [ENTRIES];
   logic [31:0] hor_mem  [ENTRIES];
   logic [31:0] hits_mem [ENTRIES];
   logic [63:0] age_mem  [ENTRIES];
   logic [63:0] cnt_rd_ff;
   logic [31:0] hor_rd_ff;
   logic [31:0] hits_rd_ff;
   logic [63:0] age_rd_ff;

   // Counters.
   logic [CNT_W-1:0] total_ff, total_in;
   logic [63:0]      age_seq_ff;

   // Lookup match results.
   logic             hit_ff;
   logic [IDX_W-1:0] hit_idx_ff;

   // Slot index counter shared by the age scan and the invalidate sweep.
   logic [IDX_W-1:0] idx_ff;

   // Age scan pipeline and results.
   logic             pv_ff;
   logic             best_found_ff;
   logic [IDX_W-1:0] best_idx_ff;
   logic [63:0]      best_age_ff;
   logic             free_found_ff;
   logic [IDX_W-1:0] free_idx_ff;
   logic             better;

   // Response register.
   logic        rsp_valid_ff, rsp_valid_in;
   krc_rsp_type rsp_ff, rsp_in;

   // Combinational match vectors.
   logic [ENTRIES-1:0] match_vec;
   logic [ENTRIES-1:0] drop_vec;
   logic [ENTRIES-1:0] victim_mask;
   logic [ENTRIES-1:0] match_eff;
   logic [ENTRIES-1:0] slot_mask;
   logic [IDX_W-1:0]   match_idx;
   logic [IDX_W-1:0]   match_eff_idx;
   logic               key_ok;

   // Insert decision signals.
   logic [31:0]      cap_ext, ent_ext, cnt_ext, limit;
   logic             evict;
   logic             upd;
   logic [IDX_W-1:0] free_slot;
   logic [IDX_W-1:0] slot;

   // Lookup resolve signals.
   logic        stale;
   logic [31:0] hits_new;

   // Per-lane compares against the request word.
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match_vec[i] = valid_ff[i] && (rel_ff[i] == req_ff.rel_id) &&
                        (key_ff[i] == req_ff.fingerprint);
         drop_vec[i]  = valid_ff[i] &&
                        ((req_ff.rel_id == 32'd0) || (rel_ff[i] == req_ff.rel_id));
      end
   end

   // Victim removal for the insert, then index encoding of the single match.
   assign victim_mask = evict ? ({{(ENTRIES-1){1'b0}}, 1'b1} << best_idx_ff) : '0;
   assign match_eff   = match_vec & ~victim_mask;

   always_comb begin
      match_idx     = '0;
      match_eff_idx = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (match_vec[i]) begin
            match_idx = match_idx | IDX_W'(i);
         end
         if (match_eff[i]) begin
            match_eff_idx = match_eff_idx | IDX_W'(i);
         end
      end
   end

   assign key_ok = (req_ff.rel_id != 32'd0) && (req_ff.fingerprint != 64'sd0);

   // Status for the controller.
   assign status.is_lookup     = (req_ff.opcode == OP_LOOKUP);
   assign status.is_insert_ok  = (req_ff.opcode == OP_INSERT) && key_ok &&
                                 (req_ff.snapshot_horizon != 32'd0);
   assign status.is_invalidate = (req_ff.opcode == OP_INVALIDATE);
   assign status.idx_last      = (idx_ff == IDX_LAST);

   // Insert decision: eviction need, victim, and the target slot.
   assign cap_ext = 32'(csr_ff);
   assign ent_ext = 32'(ENTRIES);
   assign cnt_ext = 32'(total_ff);
   assign limit   = (cap_ext < ent_ext) ? cap_ext : ent_ext;
   assign evict   = (cnt_ext >= limit) && best_found_ff;
   assign upd     = |match_eff;

   always_comb begin
      free_slot = free_idx_ff;
      if (evict && !(free_found_ff && (free_idx_ff < best_idx_ff))) begin
         free_slot = best_idx_ff;
      end
   end

   assign slot      = upd ? match_eff_idx : free_slot;
   assign slot_mask = {{(ENTRIES-1){1'b0}}, 1'b1} << slot;

   // Lookup resolve: horizon check and saturating hit count.
   assign stale    = (req_ff.snapshot_horizon == 32'd0) ||
                     (hor_rd_ff != req_ff.snapshot_horizon);
   assign hits_new = (hits_rd_ff == HITS_MAX) ? hits_rd_ff : hits_rd_ff + 32'd1;

   // Age scan compare of the word read in the previous cycle.
   assign better = pv_ff && (!best_found_ff || (age_rd_ff < best_age_ff));

   // Valid bits, occupancy and the response word.
   always_comb begin
      valid_in     = valid_ff;
      total_in     = total_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      priority if (cmd.lk_resolve) begin
         rsp_valid_in = 1'b1;
         if (!hit_ff) begin
            rsp_in.outcome = OUT_MISS;
         end else if (stale) begin
            valid_in[hit_idx_ff] = 1'b0;
            total_in             = total_ff - CNT_W'(1);
            rsp_in.outcome       = OUT_STALE;
         end else begin
            rsp_in.outcome   = OUT_HIT;
            rsp_in.count_out = cnt_rd_ff;
            rsp_in.hit_total = hits_new;
         end
      end else if (cmd.ins_apply) begin
         rsp_valid_in   = 1'b1;
         valid_in       = (valid_ff & ~victim_mask) | slot_mask;
         total_in       = total_ff - CNT_W'(evict) + CNT_W'(!upd);
         rsp_in.outcome = upd ? OUT_UPDATED : OUT_INSERTED;
         rsp_in.evicted = evict;
      end else if (cmd.sweep_step) begin
         if (drop_vec[idx_ff]) begin
            valid_in[idx_ff] = 1'b0;
            total_in         = total_ff - CNT_W'(1);
         end
         rsp_valid_in   = status.idx_last;
         rsp_in.outcome = OUT_INVALIDATED;
      end else if (cmd.reject) begin
         rsp_valid_in   = 1'b1;
         rsp_in.outcome = OUT_REJECTED;
      end else begin
         rsp_valid_in = 1'b0;
      end
      rsp_in.occupancy = OCC_W'(total_in);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff       <= CAP_RESET;
         valid_ff     <= '0;
         total_ff     <= '0;
         age_seq_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         pv_ff        <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            csr_ff <= csr_wr_data;
         end
         valid_ff     <= valid_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         pv_ff        <= cmd.scan_step && valid_ff[idx_ff];
         if (cmd.ins_apply) begin
            age_seq_ff <= age_seq_ff + 64'd1;
         end
      end
   end

   // Request capture, index counter, scan tracking and lookup match.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.idx_clear) begin
         idx_ff        <= '0;
         best_found_ff <= 1'b0;
         free_found_ff <= 1'b0;
         free_idx_ff   <= '0;
      end else begin
         if (cmd.scan_step || cmd.sweep_step) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
         if (cmd.scan_step && !valid_ff[idx_ff] && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= idx_ff;
         end
         if (better) begin
            best_found_ff <= 1'b1;
            best_idx_ff   <= idx_ff - IDX_W'(1);
            best_age_ff   <= age_rd_ff;
         end
      end
      if (cmd.lk_match) begin
         hit_ff     <= key_ok && (|match_vec);
         hit_idx_ff <= match_idx;
      end
      if (rsp_valid_in) begin
         rsp_ff <= rsp_in;
      end
   end

   // Key lanes are written when an insert creates a new entry.
   always_ff @(posedge clock) begin
      if (cmd.ins_apply && !upd) begin
         rel_ff[slot] <= req_ff.rel_id;
         key_ff[slot] <= req_ff.fingerprint;
      end
   end

   // Count, horizon and age memories: written on insert.
   always_ff @(posedge clock) begin
      if (cmd.ins_apply) begin
         cnt_mem[slot] <= req_ff.count_in;
         hor_mem[slot] <= req_ff.snapshot_horizon;
         age_mem[slot] <= age_seq_ff;
      end
      cnt_rd_ff <= cnt_mem[hit_idx_ff];
      hor_rd_ff <= hor_mem[hit_idx_ff];
      age_rd_ff <= age_mem[idx_ff];
   end

   // Hit counter memory: cleared on insert, bumped on a lookup hit.
   always_ff @(posedge clock) begin
      if (cmd.ins_apply) begin
         hits_mem[slot] <= 32'd0;
      end else if (cmd.lk_resolve && hit_ff && !stale) begin
         hits_mem[hit_idx_ff] <= hits_new;
      end
      hits_rd_ff <= hits_mem[hit_idx_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: bench/keyed_result_cache_fifo_evict_core_test.sv
// Self-checking testbench for the keyed result cache with oldest-first eviction.
// Depends on krc_pkg and keyed_result_cache_fifo_evict_core.
`timescale 1ns / 1ps

module keyed_result_cache_fifo_evict_core_test;
   import krc_pkg::*;

   localparam int SLOTS = ENTRIES_DEF;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   krc_req_type        req_data = '0;
   logic               rsp_valid;
   krc_rsp_type        rsp_data;
   logic               csr_wr_en = 1'b0;
   logic [CAP_W-1:0]   csr_wr_data = '0;

   // Shadow copy of the cache contents.
   logic               slot_valid [SLOTS];
   logic [31:0]        slot_rel [SLOTS];
   logic [63:0]        slot_key [SLOTS];
   logic [63:0]        slot_count [SLOTS];
   logic [31:0]        slot_horizon [SLOTS];
   logic [63:0]        slot_age [SLOTS];
   logic [31:0]        slot_hits [SLOTS];
   logic [63:0]        next_age = '0;
   logic [OCC_W-1:0]   live_count = '0;
   logic [CAP_W-1:0]   capacity = CAP_RESET;

   krc_rsp_type        pending_rsp [$];
   int                 mismatch_count = 0;
   int                 send_idle_pct = 13;
   int                 stall_cycles;

   // Key pools so that random lookups find what random inserts stored.
   logic [31:0]        rel_pool [6];
   logic [63:0]        key_pool [8];
   logic [31:0]        hor_pool [4];
   logic [31:0]        live_horizon = 32'd1;

   keyed_result_cache_fifo_evict_core #(.ENTRIES(SLOTS)) DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 12 ns clock.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int find_slot(input logic [31:0] rel, input logic [63:0] key);
      for (int i = 0; i < SLOTS; i++)
         if (slot_valid[i] && slot_rel[i] == rel && slot_key[i] == key)
            return i;
      return -1;
   endfunction

   function automatic void drop_slot(input int i);
      if (slot_valid[i]) begin
         slot_valid[i] = 1'b0;
         if (live_count != 0)
            live_count--;
      end
   endfunction

   // Works out the response to one word and updates the shadow cache.
   function automatic krc_rsp_type resolve_cache_word(input krc_req_type w);
      krc_rsp_type r;
      int slot;
      int limit;
      int victim;
      r = '0;
      r.outcome = OUT_REJECTED;
      case (w.opcode)
         OP_LOOKUP: begin
            r.outcome = OUT_MISS;
            if (w.rel_id != 0 && w.fingerprint != 0) begin
               slot = find_slot(w.rel_id, w.fingerprint);
               if (slot >= 0) begin
                  if (w.snapshot_horizon == 0 || slot_horizon[slot] != w.snapshot_horizon) begin
                     drop_slot(slot);
                     r.outcome = OUT_STALE;
                  end else begin
                     if (slot_hits[slot] != HITS_MAX)
                        slot_hits[slot]++;
                     r.outcome = OUT_HIT;
                     r.count_out = slot_count[slot];
                     r.hit_total = slot_hits[slot];
                  end
               end
            end
         end
         OP_INSERT: begin
            if (w.rel_id != 0 && w.fingerprint != 0 && w.snapshot_horizon != 0) begin
               limit = (capacity < SLOTS) ? capacity : SLOTS;
               // The oldest entry goes first when full, even if it holds this key.
               if (live_count >= limit) begin
                  victim = -1;
                  for (int i = 0; i < SLOTS; i++)
                     if (slot_valid[i] && (victim < 0 || slot_age[i] < slot_age[victim]))
                        victim = i;
                  if (victim >= 0) begin
                     drop_slot(victim);
                     r.evicted = 1'b1;
                  end
               end
               slot = find_slot(w.rel_id, w.fingerprint);
               if (slot >= 0) begin
                  r.outcome = OUT_UPDATED;
               end else begin
                  slot = 0;
                  while (slot < SLOTS - 1 && slot_valid[slot])
                     slot++;
                  slot_valid[slot] = 1'b1;
                  live_count++;
                  slot_rel[slot] = w.rel_id;
                  slot_key[slot] = w.fingerprint;
                  r.outcome = OUT_INSERTED;
               end
               slot_count[slot] = w.count_in;
               slot_horizon[slot] = w.snapshot_horizon;
               slot_age[slot] = next_age;
               slot_hits[slot] = '0;
               next_age++;
            end
         end
         OP_INVALIDATE: begin
            for (int i = 0; i < SLOTS; i++)
               if (slot_valid[i] && (w.rel_id == 0 || slot_rel[i] == w.rel_id))
                  drop_slot(i);
            r.outcome = OUT_INVALIDATED;
         end
         default: ;
      endcase
      r.occupancy = live_count;
      return r;
   endfunction

   function automatic krc_req_type make_word(input logic [1:0] op, input logic [31:0] rel,
                                             input logic [63:0] key, input logic [63:0] cnt,
                                             input logic [31:0] hor);
      krc_req_type w;
      w.opcode = op;
      w.rel_id = rel;
      w.fingerprint = key;
      w.count_in = cnt;
      w.snapshot_horizon = hor;
      return w;
   endfunction

   // Mostly well-formed traffic on pooled keys, with some invalid fields and noise.
   function automatic krc_req_type random_word();
      krc_req_type w;
      int pick;
      pick = $urandom_range(99);
      w.opcode = (pick < 45) ? OP_LOOKUP : (pick < 88) ? OP_INSERT :
                 (pick < 96) ? OP_INVALIDATE : OP_UNUSED;
      w.rel_id = rel_pool[$urandom_range(5)];
      w.fingerprint = key_pool[$urandom_range(7)];
      w.count_in = {$urandom, $urandom};
      if ($urandom_range(49) == 0)
         live_horizon = hor_pool[$urandom_range(3)];
      w.snapshot_horizon = ($urandom_range(9) == 0) ? hor_pool[$urandom_range(3)] : live_horizon;
      if ($urandom_range(19) == 0)
         w.rel_id = $urandom;
      if ($urandom_range(19) == 0)
         w.fingerprint = {$urandom, $urandom};
      if ($urandom_range(24) == 0)
         w.rel_id = '0;
      if ($urandom_range(24) == 0)
         w.fingerprint = '0;
      if ($urandom_range(24) == 0)
         w.snapshot_horizon = '0;
      if (w.opcode == OP_INVALIDATE && $urandom_range(3) == 0)
         w.rel_id = '0;
      return w;
   endfunction

   // Sends one word after a random gap and records its expected response.
   task automatic send_word(input krc_req_type w);
      int gap;
      gap = 0;
      while (gap < 50 && $urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      pending_rsp.push_back(resolve_cache_word(w));
   endtask

   // Capacity is written only once the cache has gone quiet.
   task automatic set_capacity(input logic [CAP_W-1:0] value);
      @(negedge clock);
      start <= 1'b0;
      while (pending_rsp.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      capacity = value;
   endtask

   task automatic test_lookup_and_insert();
      send_word(make_word(OP_LOOKUP, 32'd1, 64'd1, 64'd0, 32'd1));
      send_word(make_word(OP_INSERT, 32'd1, 64'h8000_0000_0000_0000,
                          64'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF));
      send_word(make_word(OP_LOOKUP, 32'd1, 64'h8000_0000_0000_0000, 64'd0, 32'hFFFF_FFFF));
      send_word(make_word(OP_LOOKUP, 32'd1, 64'h8000_0000_0000_0000, 64'd0, 32'hFFFF_FFFF));
      send_word(make_word(OP_INSERT, 32'hFFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
                          64'h8000_0000_0000_0000, 32'd1));
      // Overwrite of a present key.
      send_word(make_word(OP_INSERT, 32'hFFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, '1, 32'd2));
      // Horizon mismatch and lookup without a snapshot both drop the entry.
      send_word(make_word(OP_LOOKUP, 32'hFFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0, 32'd1));
      send_word(make_word(OP_LOOKUP, 32'd1, 64'h8000_0000_0000_0000, 64'd0, 32'd0));
      // Invalid lookup keys miss.
      send_word(make_word(OP_LOOKUP, 32'd0, 64'd5, 64'd0, 32'd5));
      send_word(make_word(OP_LOOKUP, 32'd5, 64'd0, 64'd0, 32'd5));
      // Invalid inserts and the unused opcode are rejected.
      send_word(make_word(OP_INSERT, 32'd0, 64'd9, 64'd9, 32'd9));
      send_word(make_word(OP_INSERT, 32'd9, 64'd0, 64'd9, 32'd9));
      send_word(make_word(OP_INSERT, 32'd9, 64'd9, 64'd9, 32'd0));
      send_word(make_word(OP_UNUSED, '1, '1, '1, '1));
   endtask

   task automatic test_invalidate();
      send_word(make_word(OP_INSERT, 32'd7, '1, 64'd0, 32'd3));
      send_word(make_word(OP_INSERT, 32'd8, 64'd1, 64'd42, 32'd3));
      send_word(make_word(OP_INVALIDATE, 32'd7, 64'd0, 64'd0, 32'd0));
      send_word(make_word(OP_LOOKUP, 32'd7, '1, 64'd0, 32'd3));
      send_word(make_word(OP_LOOKUP, 32'd8, 64'd1, 64'd0, 32'd3));
      // Relation 0 clears everything.
      send_word(make_word(OP_INVALIDATE, 32'd0, 64'd0, 64'd0, 32'd0));
   endtask

   task automatic test_capacity_eviction();
      send_word(make_word(OP_INSERT, 32'd2, 64'd10, 64'd1, 32'd4));
      send_word(make_word(OP_INSERT, 32'd2, 64'd11, 64'd2, 32'd4));
      send_word(make_word(OP_INSERT, 32'd2, 64'd12, 64'd3, 32'd4));
      // Lowered capacity evicts only one entry per insert.
      set_capacity(5'd1);
      send_word(make_word(OP_INSERT, 32'd2, 64'd13, 64'd4, 32'd4));
      set_capacity(5'd0);
      send_word(make_word(OP_INSERT, 32'd2, 64'd12, 64'd5, 32'd4));
      send_word(make_word(OP_INVALIDATE, 32'd0, 64'd0, 64'd0, 32'd0));
      send_word(make_word(OP_INSERT, 32'd3, 64'd20, 64'd6, 32'd4));
      send_word(make_word(OP_INSERT, 32'd3, 64'd21, 64'd7, 32'd4));
      set_capacity(5'd2);
      send_word(make_word(OP_INSERT, 32'd3, 64'd22, 64'd8, 32'd4));
      // The oldest entry is the key being inserted, so it comes back as new.
      send_word(make_word(OP_INSERT, 32'd3, 64'd21, 64'd9, 32'd4));
      set_capacity(5'd31);
      send_word(make_word(OP_INSERT, 32'd3, 64'd23, 64'd10, 32'd4));
   endtask

   task automatic test_random_traffic(input int idle_pct, input int words);
      logic [CAP_W-1:0] cap;
      send_idle_pct = idle_pct;
      rel_pool[0] = 32'd1;
      rel_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < 6; i++)
         rel_pool[i] = $urandom;
      key_pool[0] = 64'd1;
      key_pool[1] = 64'h8000_0000_0000_0000;
      key_pool[2] = 64'h7FFF_FFFF_FFFF_FFFF;
      key_pool[3] = '1;
      for (int i = 4; i < 8; i++)
         key_pool[i] = {$urandom, $urandom};
      hor_pool[0] = 32'd1;
      hor_pool[1] = 32'hFFFF_FFFF;
      hor_pool[2] = $urandom;
      hor_pool[3] = $urandom;
      for (int n = 0; n < words; n++) begin
         if (n % 110 == 0) begin
            case ($urandom_range(5))
               0: cap = 5'd0;
               1: cap = 5'd1;
               2: cap = 5'd16;
               3: cap = 5'd31;
               default: cap = CAP_W'($urandom_range(31));
            endcase
            set_capacity(cap);
         end
         send_word(random_word());
      end
   endtask

   // Compares each response word with the oldest expectation.
   always @(posedge clock) begin
      krc_rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $error("response word with no request outstanding: %h", rsp_data);
            mismatch_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.outcome !== want.outcome) begin
               $error("outcome expected %0d actual %0d", want.outcome, rsp_data.outcome);
               mismatch_count++;
            end
            if (rsp_data.count_out !== want.count_out) begin
               $error("count_out expected %0h actual %0h", want.count_out, rsp_data.count_out);
               mismatch_count++;
            end
            if (rsp_data.hit_total !== want.hit_total) begin
               $error("hit_total expected %0d actual %0d", want.hit_total, rsp_data.hit_total);
               mismatch_count++;
            end
            if (rsp_data.evicted !== want.evicted) begin
               $error("evicted expected %0d actual %0d", want.evicted, rsp_data.evicted);
               mismatch_count++;
            end
            if (rsp_data.occupancy !== want.occupancy) begin
               $error("occupancy expected %0d actual %0d", want.occupancy, rsp_data.occupancy);
               mismatch_count++;
            end
         end
      end
   end

   // Ends the run if no word moves on either side for too long.
   initial begin
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid)
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $error("no word moved for %0d cycles", STALL_LIMIT);
      $display("FAILURE");
      $finish;
   end

   initial begin
      for (int i = 0; i < SLOTS; i++)
         slot_valid[i] = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_lookup_and_insert();
      test_invalidate();
      test_capacity_eviction();
      test_random_traffic(13, 550);
      test_random_traffic(53, 550);
      test_random_traffic(0, 550);

      @(negedge clock);
      start <= 1'b0;
      while (pending_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/krc_pkg.sv
rtl/krc_ctrl.sv
rtl/krc_datapath.sv
rtl/keyed_result_cache_fifo_evict_core.sv
bench/keyed_result_cache_fifo_evict_core_test.sv
